// ===== sv/bpc_pkg.sv =====
// shared types, constants and helper functions for the pressure compensation block
package bpc_pkg;

   localparam int DIV_W = 32;
   localparam int CSR_ADDR_W = 5;

   localparam logic [31:0] T_OFFSET = 32'd4000;
   localparam logic [31:0] B4_BIAS = 32'd32768;
   localparam logic [31:0] B7_SCALE = 32'd50000;
   localparam logic [31:0] P_COEF_SQ = 32'd3038;
   localparam logic [31:0] P_COEF_LIN = 32'hFFFF_E343;
   localparam logic [31:0] P_COEF_OFS = 32'd3791;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_DIV_ZERO = 2'd1,
      STATUS_SAT      = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      REG_AC1_AC2  = 3'd0,
      REG_AC3_AC4  = 3'd1,
      REG_AC5_AC6  = 3'd2,
      REG_B1_B2    = 3'd3,
      REG_MC_MD    = 3'd4,
      REG_OVERSAMP = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [31:0] ac1_ac2;
      logic [31:0] ac3_ac4;
      logic [31:0] ac5_ac6;
      logic [31:0] b1_b2;
      logic [31:0] mc_md;
      logic [1:0]  oss;
   } cal_type;

   // sideband riding along the temperature divider
   typedef struct packed {
      logic [31:0] x1;
      logic [18:0] up;
      logic        neg;
      logic        dzero;
   } diva_side_type;

   // sideband riding along the pressure divider
   typedef struct packed {
      logic [11:0] t;
      logic        tsat;
      logic        dzero;
      logic        b4zero;
      logic        shift_after;
   } divb_side_type;

   function automatic logic [31:0] sx16(input logic [15:0] v);
      sx16 = {{16{v[15]}}, v};
   endfunction

   // one restoring division step on {remainder, dividend}
   function automatic logic [63:0] div_step(input logic [63:0] acc, input logic [31:0] d);
      logic [32:0] trial;
      trial = acc[63:31] - {1'b0, d};
      if (!trial[32]) begin
         div_step = {trial[31:0], acc[30:0], 1'b1};
      end else begin
         div_step = {acc[62:0], 1'b0};
      end
   endfunction

endpackage

// ===== sv/bpc_req_if.sv =====
// input channel: raw temperature and pressure words
interface bpc_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] raw_temperature;
   logic [18:0] raw_pressure;

   modport source (output valid, output raw_temperature, output raw_pressure, input ready);
   modport sink (input valid, input raw_temperature, input raw_pressure, output ready);
endinterface

// ===== sv/bpc_rsp_if.sv =====
// result channel: compensated temperature, pressure and status
interface bpc_rsp_if;
   logic        valid;
   logic        ready;
   logic [11:0] temperature_tenths;
   logic [17:0] pressure_pascal;
   logic [1:0]  status;

   modport source (output valid, output temperature_tenths, output pressure_pascal,
                   output status, input ready);
   modport sink (input valid, input temperature_tenths, input pressure_pascal,
                 input status, output ready);
endinterface

// ===== sv/bpc_csr.sv =====
// calibration and oversampling register file on an apb-style port
module bpc_csr
   import bpc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready,
   output cal_type               cal
);
   cal_type       cal_ff;
   reg_index_type idx;
   logic          wr;

   assign idx = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign wr = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cal = cal_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff <= '{default: '0, oss: 2'd3};
      end else if (wr) begin
         unique case (idx)
            REG_AC1_AC2:  cal_ff.ac1_ac2 <= csr_pwdata;
            REG_AC3_AC4:  cal_ff.ac3_ac4 <= csr_pwdata;
            REG_AC5_AC6:  cal_ff.ac5_ac6 <= csr_pwdata;
            REG_B1_B2:    cal_ff.b1_b2 <= csr_pwdata;
            REG_MC_MD:    cal_ff.mc_md <= csr_pwdata;
            REG_OVERSAMP: cal_ff.oss <= csr_pwdata[1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_AC1_AC2:  csr_prdata = cal_ff.ac1_ac2;
         REG_AC3_AC4:  csr_prdata = cal_ff.ac3_ac4;
         REG_AC5_AC6:  csr_prdata = cal_ff.ac5_ac6;
         REG_B1_B2:    csr_prdata = cal_ff.b1_b2;
         REG_MC_MD:    csr_prdata = cal_ff.mc_md;
         REG_OVERSAMP: csr_prdata = {30'd0, cal_ff.oss};
         default:      csr_prdata = '0;
      endcase
   end
endmodule

// ===== sv/bpc_div_pipe.sv =====
// pipelined unsigned 32-bit divider, one quotient bit per stage
module bpc_div_pipe
   import bpc_pkg::*;
#(
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [DIV_W-1:0]  num,
   input  logic [DIV_W-1:0]  den,
   input  logic [SIDE_W-1:0] side_in,
   output logic              out_valid,
   output logic [DIV_W-1:0]  quot,
   output logic [SIDE_W-1:0] side_out
);
   logic [2*DIV_W-1:0] acc_ff  [DIV_W];
   logic [2*DIV_W-1:0] acc_in  [DIV_W];
   logic [DIV_W-1:0]   den_ff  [DIV_W];
   logic [SIDE_W-1:0]  side_ff [DIV_W];
   logic               vld_ff  [DIV_W];

   always_comb begin
      acc_in[0] = div_step({{DIV_W{1'b0}}, num}, den);
      for (int k = 1; k < DIV_W; k++) begin
         acc_in[k] = div_step(acc_ff[k-1], den_ff[k-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIV_W; k++) vld_ff[k] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
         for (int k = 1; k < DIV_W; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         acc_ff[0] <= acc_in[0];
         den_ff[0] <= den;
         side_ff[0] <= side_in;
         for (int k = 1; k < DIV_W; k++) begin
            acc_ff[k] <= acc_in[k];
            den_ff[k] <= den_ff[k-1];
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign out_valid = vld_ff[DIV_W-1];
   assign quot = acc_ff[DIV_W-1][DIV_W-1:0];
   assign side_out = side_ff[DIV_W-1];
endmodule

// ===== sv/barometric_pressure_compensation.sv =====
// a req transfer reaches rsp valid through two 32-stage dividers plus 9 stages
// throughput: one transfer per cycle; a stalled rsp freezes the whole pipeline
// the pipeline is one chain of registers moved by a single enable, so nothing is lost
// reset: synchronous, active high; clears all valid bits, calibration to 0, oversampling to 3
// calibration is read live by stages 1-2, 4-7 and must only change while the block is empty
module barometric_pressure_compensation
   import bpc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   bpc_req_if.sink               req_chan,
   bpc_rsp_if.source             rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);
   cal_type cal;
   logic    en;

   logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;

   bpc_csr u_csr (
      .clock, .reset, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr,
      .csr_pwdata, .csr_prdata, .csr_pready, .cal
   );

   // unpack calibration coefficients
   assign ac1 = sx16(cal.ac1_ac2[31:16]);
   assign ac2 = sx16(cal.ac1_ac2[15:0]);
   assign ac3 = sx16(cal.ac3_ac4[31:16]);
   assign ac4 = {16'd0, cal.ac3_ac4[15:0]};
   assign ac5 = {16'd0, cal.ac5_ac6[31:16]};
   assign ac6 = {16'd0, cal.ac5_ac6[15:0]};
   assign b1  = sx16(cal.b1_b2[31:16]);
   assign b2  = sx16(cal.b1_b2[15:0]);
   assign mc  = sx16(cal.mc_md[31:16]);
   assign md  = sx16(cal.mc_md[15:0]);

   // whole pipeline moves unless the output register holds an untaken result
   logic rsp_vld_ff;
   assign en = !rsp_vld_ff || rsp_chan.ready;
   assign req_chan.ready = en;

   // stage 1: x1 = ((ut - ac6) * ac5) >> 15
   logic        s1_vld_ff;
   logic [31:0] s1_x1_ff;
   logic [18:0] s1_up_ff;
   logic [31:0] s1_prod;

   assign s1_prod = ({16'd0, req_chan.raw_temperature} - ac6) * ac5;

   always_ff @(posedge clock) begin
      if (reset) s1_vld_ff <= 1'b0;
      else if (en) s1_vld_ff <= req_chan.valid;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         s1_x1_ff <= 32'($signed(s1_prod) >>> 15);
         s1_up_ff <= req_chan.raw_pressure;
      end
   end

   // temperature divider: x2 = (mc << 11) / (x1 + md), sign-magnitude
   logic [31:0]   da_den, da_num, da_mnum, da_mden, da_quot;
   diva_side_type da_side_in, da_side_out;
   logic          da_vld;

   always_comb begin
      da_den = s1_x1_ff + md;
      da_num = mc << 11;
      da_mnum = da_num[31] ? 32'd0 - da_num : da_num;
      da_mden = da_den[31] ? 32'd0 - da_den : da_den;
      da_side_in.x1 = s1_x1_ff;
      da_side_in.up = s1_up_ff;
      da_side_in.neg = da_num[31] ^ da_den[31];
      da_side_in.dzero = (da_den == 32'd0);
      // keep the divider defined on a zero divisor; the result is dropped
      if (da_side_in.dzero) da_mden = 32'd1;
   end

   bpc_div_pipe #(.SIDE_W($bits(diva_side_type))) u_div_temp (
      .clock, .reset, .en,
      .in_valid(s1_vld_ff), .num(da_mnum), .den(da_mden), .side_in(da_side_in),
      .out_valid(da_vld), .quot(da_quot), .side_out(da_side_out)
   );

   // stage 3: b5, temperature with saturation, b6
   logic        s3_vld_ff, s3_tsat_ff, s3_dzero_ff;
   logic [31:0] s3_b6_ff;
   logic [11:0] s3_t_ff;
   logic [18:0] s3_up_ff;
   logic [31:0] s3_x2, s3_b5, s3_t32;
   logic [11:0] s3_t;
   logic        s3_tsat;

   always_comb begin
      s3_x2 = da_side_out.neg ? 32'd0 - da_quot : da_quot;
      s3_b5 = da_side_out.x1 + s3_x2;
      s3_t32 = 32'($signed(s3_b5 + 32'd8) >>> 4);
      s3_tsat = 1'b1;
      if ($signed(s3_t32) > 32'sd2047) s3_t = 12'h7FF;
      else if ($signed(s3_t32) < -32'sd2048) s3_t = 12'h800;
      else begin
         s3_t = s3_t32[11:0];
         s3_tsat = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) s3_vld_ff <= 1'b0;
      else if (en) s3_vld_ff <= da_vld;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         s3_b6_ff <= s3_b5 - T_OFFSET;
         s3_t_ff <= s3_t;
         s3_tsat_ff <= s3_tsat;
         s3_dzero_ff <= da_side_out.dzero;
         s3_up_ff <= da_side_out.up;
      end
   end

   // stage 4: b6 squared and the two linear b6 terms
   logic        s4_vld_ff, s4_tsat_ff, s4_dzero_ff;
   logic [31:0] s4_sq_ff, s4_x2a_ff, s4_x1c_ff;
   logic [11:0] s4_t_ff;
   logic [18:0] s4_up_ff;
   logic [31:0] s4_sqp, s4_ac2p, s4_ac3p;

   assign s4_sqp  = s3_b6_ff * s3_b6_ff;
   assign s4_ac2p = ac2 * s3_b6_ff;
   assign s4_ac3p = ac3 * s3_b6_ff;

   always_ff @(posedge clock) begin
      if (reset) s4_vld_ff <= 1'b0;
      else if (en) s4_vld_ff <= s3_vld_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         s4_sq_ff <= 32'($signed(s4_sqp) >>> 12);
         s4_x2a_ff <= 32'($signed(s4_ac2p) >>> 11);
         s4_x1c_ff <= 32'($signed(s4_ac3p) >>> 13);
         s4_t_ff <= s3_t_ff;
         s4_tsat_ff <= s3_tsat_ff;
         s4_dzero_ff <= s3_dzero_ff;
         s4_up_ff <= s3_up_ff;
      end
   end

   // stage 5: b2 and b1 terms on the square
   logic        s5_vld_ff, s5_tsat_ff, s5_dzero_ff;
   logic [31:0] s5_x1b_ff, s5_x2a_ff, s5_x1c_ff, s5_x2b_ff;
   logic [11:0] s5_t_ff;
   logic [18:0] s5_up_ff;
   logic [31:0] s5_b2p, s5_b1p;

   assign s5_b2p = b2 * s4_sq_ff;
   assign s5_b1p = b1 * s4_sq_ff;

   always_ff @(posedge clock) begin
      if (reset) s5_vld_ff <= 1'b0;
      else if (en) s5_vld_ff <= s4_vld_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         s5_x1b_ff <= 32'($signed(s5_b2p) >>> 11);
         s5_x2b_ff <= 32'($signed(s5_b1p) >>> 16);
         s5_x2a_ff <= s4_x2a_ff;
         s5_x1c_ff <= s4_x1c_ff;
         s5_t_ff <= s4_t_ff;
         s5_tsat_ff <= s4_tsat_ff;
         s5_dzero_ff <= s4_dzero_ff;
         s5_up_ff <= s4_up_ff;
      end
   end

   // stage 6: b3 and the b4 bracket
   logic        s6_vld_ff, s6_tsat_ff, s6_dzero_ff;
   logic [31:0] s6_b3_ff, s6_x3_ff;
   logic [11:0] s6_t_ff;
   logic [18:0] s6_up_ff;
   logic [31:0] s6_x3a, s6_b3s, s6_x3b;

   always_comb begin
      s6_x3a = s5_x1b_ff + s5_x2a_ff;
      s6_b3s = ((ac1 << 2) + s6_x3a) << cal.oss;
      s6_x3b = s5_x1c_ff + s5_x2b_ff + 32'd2;
   end

   always_ff @(posedge clock) begin
      if (reset) s6_vld_ff <= 1'b0;
      else if (en) s6_vld_ff <= s5_vld_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         s6_b3_ff <= 32'($signed(s6_b3s + 32'd2) >>> 2);
         s6_x3_ff <= 32'($signed(s6_x3b) >>> 2);
         s6_t_ff <= s5_t_ff;
         s6_tsat_ff <= s5_tsat_ff;
         s6_dzero_ff <= s5_dzero_ff;
         s6_up_ff <= s5_up_ff;
      end
   end

   // stage 7: b4 and b7
   logic        s7_vld_ff, s7_tsat_ff, s7_dzero_ff;
   logic [31:0] s7_b4_ff, s7_b7_ff;
   logic [11:0] s7_t_ff;
   logic [31:0] s7_b4p, s7_b7p;

   assign s7_b4p = ac4 * (s6_x3_ff + B4_BIAS);
   assign s7_b7p = ({13'd0, s6_up_ff} - s6_b3_ff) * (B7_SCALE >> cal.oss);

   always_ff @(posedge clock) begin
      if (reset) s7_vld_ff <= 1'b0;
      else if (en) s7_vld_ff <= s6_vld_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         s7_b4_ff <= s7_b4p >> 15;
         s7_b7_ff <= s7_b7p;
         s7_t_ff <= s6_t_ff;
         s7_tsat_ff <= s6_tsat_ff;
         s7_dzero_ff <= s6_dzero_ff;
      end
   end

   // pressure divider: doubled dividend when it fits, else double the quotient
   logic [31:0]   db_num, db_den, db_quot;
   divb_side_type db_side_in, db_side_out;
   logic          db_vld;

   always_comb begin
      db_side_in.t = s7_t_ff;
      db_side_in.tsat = s7_tsat_ff;
      db_side_in.dzero = s7_dzero_ff;
      db_side_in.b4zero = (s7_b4_ff == 32'd0);
      db_side_in.shift_after = s7_b7_ff[31];
      db_num = s7_b7_ff[31] ? s7_b7_ff : s7_b7_ff << 1;
      db_den = db_side_in.b4zero ? 32'd1 : s7_b4_ff;
   end

   bpc_div_pipe #(.SIDE_W($bits(divb_side_type))) u_div_press (
      .clock, .reset, .en,
      .in_valid(s7_vld_ff), .num(db_num), .den(db_den), .side_in(db_side_in),
      .out_valid(db_vld), .quot(db_quot), .side_out(db_side_out)
   );

   // stage 9: square and linear correction products
   logic          s9_vld_ff;
   logic [31:0]   s9_p_ff, s9_sq_ff, s9_lin_ff;
   divb_side_type s9_side_ff;
   logic [31:0]   s9_p, s9_xa;

   always_comb begin
      s9_p = db_side_out.shift_after ? db_quot << 1 : db_quot;
      s9_xa = 32'($signed(s9_p) >>> 8);
   end

   always_ff @(posedge clock) begin
      if (reset) s9_vld_ff <= 1'b0;
      else if (en) s9_vld_ff <= db_vld;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         s9_p_ff <= s9_p;
         s9_sq_ff <= s9_xa * s9_xa;
         s9_lin_ff <= P_COEF_LIN * s9_p;
         s9_side_ff <= db_side_out;
      end
   end

   // stage 10: scale the square term
   logic          s10_vld_ff;
   logic [31:0]   s10_p_ff, s10_x1_ff, s10_x2_ff;
   divb_side_type s10_side_ff;
   logic [31:0]   s10_prod;

   assign s10_prod = s9_sq_ff * P_COEF_SQ;

   always_ff @(posedge clock) begin
      if (reset) s10_vld_ff <= 1'b0;
      else if (en) s10_vld_ff <= s9_vld_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         s10_p_ff <= s9_p_ff;
         s10_x1_ff <= 32'($signed(s10_prod) >>> 16);
         s10_x2_ff <= 32'($signed(s9_lin_ff) >>> 16);
         s10_side_ff <= s9_side_ff;
      end
   end

   // stage 11: final pressure, saturation, status, into the output register
   logic [31:0] s11_pf, s11_corr;
   logic [17:0] s11_p;
   logic        s11_psat;
   status_type  s11_status;
   logic [11:0] s11_t;

   always_comb begin
      s11_corr = s10_x1_ff + s10_x2_ff + P_COEF_OFS;
      s11_pf = s10_p_ff + 32'($signed(s11_corr) >>> 4);
      s11_psat = 1'b1;
      if ($signed(s11_pf) > 32'sd262143) s11_p = 18'h3FFFF;
      else if ($signed(s11_pf) < 32'sd0) s11_p = 18'd0;
      else begin
         s11_p = s11_pf[17:0];
         s11_psat = 1'b0;
      end
      s11_t = s10_side_ff.t;
      if (s10_side_ff.dzero) begin
         // temperature divisor zero: everything blanked
         s11_t = 12'd0;
         s11_p = 18'd0;
         s11_status = STATUS_DIV_ZERO;
      end else if (s10_side_ff.b4zero) begin
         s11_p = 18'd0;
         s11_status = STATUS_DIV_ZERO;
      end else if (s10_side_ff.tsat || s11_psat) begin
         s11_status = STATUS_SAT;
      end else begin
         s11_status = STATUS_OK;
      end
   end

   logic [11:0] rsp_t_ff;
   logic [17:0] rsp_p_ff;
   status_type  rsp_status_ff;

   always_ff @(posedge clock) begin
      if (reset) rsp_vld_ff <= 1'b0;
      else if (en) rsp_vld_ff <= s10_vld_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         rsp_t_ff <= s11_t;
         rsp_p_ff <= s11_p;
         rsp_status_ff <= s11_status;
      end
   end

   assign rsp_chan.valid = rsp_vld_ff;
   assign rsp_chan.temperature_tenths = rsp_t_ff;
   assign rsp_chan.pressure_pascal = rsp_p_ff;
   assign rsp_chan.status = rsp_status_ff;
endmodule

// ===== test/barometric_pressure_compensation_checker.sv =====
// checker for the pressure compensation block: predicts each result and compares it
module barometric_pressure_compensation_checker
   import bpc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   bpc_req_if          req_chan,
   bpc_rsp_if          rsp_chan,
   input  logic [31:0] cal_word [0:4],
   input  logic [1:0]  oss_setting,
   output int          fail_count,
   output int          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [11:0] temperature;
      logic [17:0] pressure;
      status_type  status;
   } reading_type;

   reading_type expected_readings[$];

   function automatic logic [31:0] ext16(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   function automatic logic [31:0] shr_arith(input logic [31:0] x, input int n);
      return $signed(x) >>> n;
   endfunction

   function automatic logic [31:0] quot_signed(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] ma, mb, q;
      ma = a[31] ? -a : a;
      mb = b[31] ? -b : b;
      q = ma / mb;
      return (a[31] != b[31]) ? -q : q;
   endfunction

   function automatic reading_type compensate(input logic [15:0] ut_raw,
                                              input logic [18:0] up_raw);
      logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
      logic [31:0] ut, up, x1, x2, x3, b5, b6, b3, b4, b7, p, den, sq, tw;
      longint t, pr;
      int oss;
      reading_type r;
      ac1 = ext16(cal_word[0][31:16]); ac2 = ext16(cal_word[0][15:0]);
      ac3 = ext16(cal_word[1][31:16]); ac4 = {16'd0, cal_word[1][15:0]};
      ac5 = {16'd0, cal_word[2][31:16]}; ac6 = {16'd0, cal_word[2][15:0]};
      b1 = ext16(cal_word[3][31:16]); b2 = ext16(cal_word[3][15:0]);
      mc = ext16(cal_word[4][31:16]); md = ext16(cal_word[4][15:0]);
      oss = oss_setting;
      ut = {16'd0, ut_raw};
      up = {13'd0, up_raw};
      r.status = STATUS_OK;
      x1 = shr_arith((ut - ac6) * ac5, 15);
      den = x1 + md;
      if (den == 0) begin
         r.temperature = '0; r.pressure = '0; r.status = STATUS_DIV_ZERO;
         return r;
      end
      x2 = quot_signed(mc << 11, den);
      b5 = x1 + x2;
      tw = shr_arith(b5 + 32'd8, 4);
      t = longint'($signed(tw));
      if (t > 2047) begin t = 2047; r.status = STATUS_SAT; end
      if (t < -2048) begin t = -2048; r.status = STATUS_SAT; end
      r.temperature = t[11:0];
      b6 = b5 - T_OFFSET;
      sq = shr_arith(b6 * b6, 12);
      x1 = shr_arith(b2 * sq, 11);
      x2 = shr_arith(ac2 * b6, 11);
      x3 = x1 + x2;
      b3 = shr_arith(((ac1 * 32'd4 + x3) << oss) + 32'd2, 2);
      x1 = shr_arith(ac3 * b6, 13);
      x2 = shr_arith(b1 * sq, 16);
      x3 = shr_arith(x1 + x2 + 32'd2, 2);
      b4 = (ac4 * (x3 + B4_BIAS)) >> 15;
      b7 = (up - b3) * (B7_SCALE >> oss);
      if (b4 == 0) begin
         r.pressure = '0; r.status = STATUS_DIV_ZERO;
         return r;
      end
      if (!b7[31]) p = (b7 << 1) / b4;
      else p = (b7 / b4) << 1;
      x1 = shr_arith(p, 8);
      x1 = x1 * x1;
      x1 = shr_arith(x1 * P_COEF_SQ, 16);
      x2 = shr_arith(P_COEF_LIN * p, 16);
      p = p + shr_arith(x1 + x2 + P_COEF_OFS, 4);
      pr = longint'($signed(p));
      if (pr > 262143) begin pr = 262143; r.status = STATUS_SAT; end
      if (pr < 0) begin pr = 0; r.status = STATUS_SAT; end
      r.pressure = pr[17:0];
      return r;
   endfunction

   always @(posedge clock) begin
      reading_type want;
      if (reset) begin
         fail_count <= 0;
         pending_count <= 0;
      end else begin
         if (req_chan.valid && req_chan.ready)
            expected_readings.push_back(compensate(req_chan.raw_temperature,
                                                   req_chan.raw_pressure));
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_readings.size() == 0) begin
               $display("%0t: unexpected result t=%0d p=%0d s=%0d", $time,
                        rsp_chan.temperature_tenths, rsp_chan.pressure_pascal,
                        rsp_chan.status);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_readings.pop_front();
               if (rsp_chan.temperature_tenths !== want.temperature ||
                   rsp_chan.pressure_pascal !== want.pressure ||
                   rsp_chan.status !== want.status) begin
                  $display("%0t: mismatch expected t=%0d p=%0d s=%0d actual t=%0d p=%0d s=%0d",
                           $time, $signed(want.temperature), want.pressure, want.status,
                           $signed(rsp_chan.temperature_tenths), rsp_chan.pressure_pascal,
                           rsp_chan.status);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending_count <= expected_readings.size();
      end
   end
endmodule

// ===== test/barometric_pressure_compensation_test.sv =====
// top of the pressure compensation testbench: clock, stimulus, register writes and verdict
module barometric_pressure_compensation_test;
   import bpc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY = 73;
   localparam int STALL_LIMIT = 5000;

   logic clock;
   logic reset;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;
   logic csr_pready;

   // shadow of the calibration, shared with the checker
   logic [31:0] cal_word [0:4];
   logic [1:0]  oss_setting;
   int fail_count, pending_count;
   int idle_cycles;
   bit long_hold;

   bpc_req_if req_chan ();
   bpc_rsp_if rsp_chan ();

   barometric_pressure_compensation DUT (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   barometric_pressure_compensation_checker checker_inst (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .cal_word(cal_word), .oss_setting(oss_setting),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // setup then access phase; the shadow copy follows at the write edge
   task automatic write_register(input reg_index_type idx, input logic [31:0] value);
      csr_psel <= 1; csr_penable <= 0; csr_pwrite <= 1;
      csr_paddr <= CSR_ADDR_W'(idx) << 2; csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      if (idx == REG_OVERSAMP) oss_setting = value[1:0];
      else cal_word[idx] = value;
   endtask

   task automatic load_calibration(input logic [31:0] w0, input logic [31:0] w1,
                                   input logic [31:0] w2, input logic [31:0] w3,
                                   input logic [31:0] w4, input logic [1:0] oss);
      write_register(REG_AC1_AC2, w0);
      write_register(REG_AC3_AC4, w1);
      write_register(REG_AC5_AC6, w2);
      write_register(REG_B1_B2, w3);
      write_register(REG_MC_MD, w4);
      write_register(REG_OVERSAMP, {30'd0, oss});
   endtask

   // typical factory coefficients of this sensor family
   task automatic load_datasheet_calibration(input logic [1:0] oss);
      load_calibration({16'd408, 16'hFEB8}, {16'hC7D1, 16'd32741}, {16'd32757, 16'd23153},
                       {16'd6190, 16'd4}, {16'h8000, 16'd2868}, oss);
   endtask

   // random coefficients near the typical set, occasionally wild
   task automatic load_random_calibration();
      if ($urandom_range(0, 3) == 0)
         load_calibration($urandom, $urandom, $urandom, $urandom, $urandom,
                          2'($urandom_range(0, 3)));
      else
         load_calibration({16'(408 + $urandom_range(0, 200) - 100),
                           16'(-72 - 16'($urandom_range(0, 60)))},
                          {16'(-14383 + $urandom_range(0, 400)),
                           16'(32000 + $urandom_range(0, 1500))},
                          {16'(32000 + $urandom_range(0, 1500)),
                           16'(23000 + $urandom_range(0, 400))},
                          {16'(6000 + $urandom_range(0, 400)), 16'($urandom_range(0, 10))},
                          {16'(-11786 + $urandom_range(0, 3000)),
                           16'(2500 + $urandom_range(0, 800))},
                          2'($urandom_range(0, 3)));
   endtask

   // one transfer, held until the block takes it
   task automatic send_reading(input logic [15:0] ut, input logic [18:0] up);
      req_chan.valid <= 1;
      req_chan.raw_temperature <= ut;
      req_chan.raw_pressure <= up;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic send_gap();
      req_chan.valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clock);
   endtask

   // lets the pipeline drain before touching the registers
   task automatic drain();
      req_chan.valid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   task automatic send_random_block(input int count);
      int burst;
      while (count > 0) begin
         burst = $urandom_range(1, 40);
         while (burst > 0 && count > 0) begin
            // mostly realistic raw words, with full-range noise mixed in
            if ($urandom_range(0, 4) == 0)
               send_reading(16'($urandom), 19'($urandom));
            else
               send_reading(16'(27898 + $urandom_range(0, 8000) - 4000),
                            19'(($urandom_range(18000, 30000) << oss_setting)
                                + $urandom_range(0, 7)));
            burst--; count--;
         end
         if ($urandom_range(0, 2) != 0) send_gap();
      end
   endtask

   // receiver: random stall pattern, full-speed stretches, and one long hold-off
   initial begin
      int mode;
      rsp_chan.ready <= 0;
      @(negedge reset);
      forever begin
         if (long_hold) begin
            rsp_chan.ready <= 0;
            repeat (400) @(posedge clock);
            long_hold = 0;
         end
         mode = $urandom_range(0, 2);
         repeat ($urandom_range(10, 60)) begin
            rsp_chan.ready <= (mode == 0) ? 1'b1 : ($urandom_range(0, 3) != 0);
            @(posedge clock);
         end
      end
   end

   // watchdog on transfers of either channel
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      req_chan.valid = 0;
      req_chan.raw_temperature = 0;
      req_chan.raw_pressure = 0;
      csr_psel = 0; csr_penable = 0; csr_pwrite = 0; csr_paddr = 0; csr_pwdata = 0;
      for (int i = 0; i < 5; i++) cal_word[i] = 0;
      oss_setting = 3;
      long_hold = 0;
      reset = 1;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // reset calibration gives a zero temperature divisor whenever x1 + md is 0
      send_reading(16'd0, 19'd0);
      send_reading(16'hFFFF, 19'h7FFFF);
      drain();

      // typical coefficients, raw extremes and the usual operating point
      load_datasheet_calibration(2'd0);
      send_reading(16'd27898, 19'd23843);
      send_reading(16'd0, 19'd0);
      send_reading(16'hFFFF, 19'h7FFFF);
      send_reading(16'h8000, 19'h40000);
      send_reading(16'd27898, 19'h7FFFF);
      drain();
      load_datasheet_calibration(2'd3);
      send_reading(16'd27898, 19'd190744);
      send_reading(16'hFFFF, 19'd0);
      send_reading(16'd0, 19'h7FFFF);
      drain();

      // zero pressure divisor: ac4 of zero forces b4 to zero
      load_calibration({16'd408, 16'hFEB8}, {16'hC7D1, 16'd0}, {16'd32757, 16'd23153},
                       {16'd6190, 16'd4}, {16'h8000, 16'd2868}, 2'd1);
      send_reading(16'd27898, 19'd50000);
      drain();

      // extreme coefficients in both signs push saturation of temperature and pressure
      load_calibration(32'h7FFF_7FFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_7FFF,
                       32'h7FFF_0001, 2'd2);
      send_reading(16'd0, 19'h7FFFF);
      send_reading(16'hFFFF, 19'd0);
      send_reading(16'd12345, 19'd1);
      drain();
      load_calibration(32'h8000_8000, 32'h8000_0001, 32'h0001_0000, 32'h8000_8000,
                       32'h8000_8000, 2'd0);
      send_reading(16'd0, 19'h7FFFF);
      send_reading(16'hFFFF, 19'd0);
      send_reading(16'h5555, 19'h2AAAA);
      drain();

      // long receiver hold-off while the sender keeps offering
      load_datasheet_calibration(2'd1);
      long_hold = 1;
      send_random_block(250);
      drain();

      // random phases, each under its own calibration
      for (int phase = 0; phase < 8; phase++) begin
         load_random_calibration();
         send_random_block(200);
         drain();
      end

      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
